// ===== hw/rtl/mma_pkg.sv =====
// ----------------------------------------------------------------------------
// mma_pkg
// Types and constants shared by the MIDI message assembler modules.
// ----------------------------------------------------------------------------
package mma_pkg;

  localparam logic [7:0] STATUS_BIT_MASK = 8'h80;
  localparam logic [7:0] STATUS_HI_MASK  = 8'hF0;
  localparam logic [7:0] STATUS_PROG     = 8'hC0;
  localparam logic [7:0] STATUS_CHAN_AT  = 8'hD0;
  localparam logic [7:0] STATUS_META     = 8'hFF;
  localparam logic [7:0] DATA_ZERO       = 8'h00;

  localparam logic KIND_MIDI = 1'b0;
  localparam logic KIND_TEXT = 1'b1;

  typedef enum logic [1:0] {
    MODE_MIDI = 2'd0,
    MODE_LEN  = 2'd1,
    MODE_TEXT = 2'd2
  } mode_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] status_byte;
    logic [6:0] data_first;
    logic [6:0] data_second;
    logic [7:0] text_byte;
    logic       text_last;
  } result_t;

endpackage

// ===== hw/rtl/mma_in_stage.sv =====
// ----------------------------------------------------------------------------
// mma_in_stage
// Input register: holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
module mma_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       advance,
  output logic       byte_valid,
  output logic [7:0] byte_data
);
  import mma_pkg::*;

  logic       valid_r;
  logic [7:0] byte_r;
  logic       take;

  assign in_stall   = valid_r && !advance;
  assign take       = in_valid && !in_stall;
  assign byte_valid = valid_r;
  assign byte_data  = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= in_rx_byte;
    end
  end

endmodule

// ===== hw/rtl/mma_parser.sv =====
// ----------------------------------------------------------------------------
// mma_parser
// Running-status parser state and the per-byte decode of one item.
// ----------------------------------------------------------------------------
module mma_parser #(
  parameter int MAX_TEXT = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  logic [7:0]       rx_byte,
  input  logic             show_comments,
  output logic             res_valid,
  output mma_pkg::result_t res
);
  import mma_pkg::*;

  localparam int RemW = $clog2(MAX_TEXT);
  localparam logic [RemW-1:0] LenMax = RemW'(MAX_TEXT - 1);

  mode_t           mode_r, mode_nxt;
  logic            have_status_r, have_status_nxt;
  logic [7:0]      status_r, status_nxt;
  logic [6:0]      first_r, first_nxt;
  logic            second_r, second_nxt;   // waiting for second data byte
  logic [RemW-1:0] rem_r, rem_nxt;

  logic            is_status;
  logic            one_data;
  logic            is_comment;
  logic            text_last;
  logic [RemW-1:0] len;

  assign is_status  = (rx_byte & STATUS_BIT_MASK) != DATA_ZERO;
  assign one_data   = ((status_r & STATUS_HI_MASK) == STATUS_PROG) ||
                      ((status_r & STATUS_HI_MASK) == STATUS_CHAN_AT);
  assign is_comment = (status_r == STATUS_META) && (first_r == DATA_ZERO[6:0]) &&
                      (rx_byte == DATA_ZERO);
  assign text_last  = rem_r <= RemW'(1);
  assign len        = ({1'b0, rx_byte} > 9'(MAX_TEXT - 1)) ? LenMax : rx_byte[RemW-1:0];

  // next state
  always_comb begin
    mode_nxt        = mode_r;
    have_status_nxt = have_status_r;
    status_nxt      = status_r;
    first_nxt       = first_r;
    second_nxt      = second_r;
    rem_nxt         = rem_r;
    case (mode_r)
      MODE_LEN: begin
        rem_nxt  = len;
        mode_nxt = (len == '0) ? MODE_MIDI : MODE_TEXT;
      end
      MODE_TEXT: begin
        rem_nxt = text_last ? '0 : rem_r - RemW'(1);
        if (text_last) begin
          mode_nxt = MODE_MIDI;
        end
      end
      default: begin
        if (is_status) begin
          status_nxt      = rx_byte;
          have_status_nxt = 1'b1;
          second_nxt      = 1'b0;
        end else if (have_status_r) begin
          if (!second_r) begin
            if (!one_data) begin
              first_nxt  = rx_byte[6:0];
              second_nxt = 1'b1;
            end
          end else begin
            second_nxt = 1'b0;
            // comment opener: status is forgotten afterwards
            if (is_comment) begin
              mode_nxt        = MODE_LEN;
              have_status_nxt = 1'b0;
              status_nxt      = '0;
              first_nxt       = '0;
            end
          end
        end
      end
    endcase
  end

  // result
  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    case (mode_r)
      MODE_LEN: begin
        res_valid = 1'b0;
      end
      MODE_TEXT: begin
        res_valid     = show_comments;
        res.kind      = KIND_TEXT;
        res.text_byte = rx_byte;
        res.text_last = text_last;
      end
      default: begin
        if (!is_status && have_status_r) begin
          res.kind        = KIND_MIDI;
          res.status_byte = status_r;
          if (!second_r) begin
            res_valid       = one_data;
            res.data_first  = rx_byte[6:0];
          end else begin
            res_valid       = !is_comment;
            res.data_first  = first_r;
            res.data_second = rx_byte[6:0];
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_MIDI;
      have_status_r <= 1'b0;
      status_r      <= '0;
      first_r       <= '0;
      second_r      <= 1'b0;
      rem_r         <= '0;
    end else if (advance) begin
      mode_r        <= mode_nxt;
      have_status_r <= have_status_nxt;
      status_r      <= status_nxt;
      first_r       <= first_nxt;
      second_r      <= second_nxt;
      rem_r         <= rem_nxt;
    end
  end

endmodule

// ===== hw/rtl/mma_out_stage.sv =====
// ----------------------------------------------------------------------------
// mma_out_stage
// Result register: holds one finished item until the consumer takes it.
// ----------------------------------------------------------------------------
module mma_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  mma_pkg::result_t res,
  output logic             out_free,
  output logic             out_valid,
  input  logic             out_stall,
  output mma_pkg::result_t out_res
);
  import mma_pkg::*;

  logic    valid_r;
  result_t res_r;

  assign out_free  = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

// ===== hw/rtl/midi_message_assembler_unit.sv =====
// ----------------------------------------------------------------------------
// midi_message_assembler_unit
// Assembles MIDI channel messages with running status from received bytes.
// ----------------------------------------------------------------------------
// One received byte per item; a new byte can be accepted every clock cycle
// while in_stall is low, each byte passing through an input register, the
// combinational decode and a result register before its result is presented.
// A completed message or a comment text byte gives one result; all other
// bytes give none. A stall on the output only holds the input side once both
// registers are full. show_comments should only be written while the unit is
// idle; cfg_ready is always high.
module midi_message_assembler_unit #(
  parameter int MAX_TEXT = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_show_comments,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_kind,
  output logic [7:0] out_status_byte,
  output logic [6:0] out_data_first,
  output logic [6:0] out_data_second,
  output logic [7:0] out_text_byte,
  output logic       out_text_last
);
  import mma_pkg::*;

  logic       show_comments_r;
  logic       byte_valid;
  logic [7:0] byte_data;
  logic       advance;
  logic       res_valid;
  logic       out_free;
  result_t    res;
  result_t    out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      show_comments_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      show_comments_r <= cfg_show_comments;
    end
  end

  // an item with no result never waits for the result register
  assign advance = byte_valid && (out_free || !res_valid);

  mma_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .advance    (advance),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  mma_parser #(
    .MAX_TEXT (MAX_TEXT)
  ) u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .advance       (advance),
    .rx_byte       (byte_data),
    .show_comments (show_comments_r),
    .res_valid     (res_valid),
    .res           (res)
  );

  mma_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && res_valid),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_kind        = out_res.kind;
  assign out_status_byte = out_res.status_byte;
  assign out_data_first  = out_res.data_first;
  assign out_data_second = out_res.data_second;
  assign out_text_byte   = out_res.text_byte;
  assign out_text_last   = out_res.text_last;

endmodule

// ===== tb/sv/midi_message_assembler_checker.sv =====
// ----------------------------------------------------------------------------
// midi_message_assembler_checker
// Watches the byte, result and show_comments channels of the MIDI message
// assembler, works out the message or text byte each accepted byte should
// give, and compares every accepted result with the oldest one still owed.
// ----------------------------------------------------------------------------
module midi_message_assembler_checker #(
  parameter int MAX_TEXT = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic       cfg_show_comments,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       out_kind,
  input  logic [7:0] out_status_byte,
  input  logic [6:0] out_data_first,
  input  logic [6:0] out_data_second,
  input  logic [7:0] out_text_byte,
  input  logic       out_text_last,
  output int         fail_count,
  output int         pending
);
  import mma_pkg::*;

  result_t    owed_results[$];
  logic       show_text;
  logic       have_status;
  logic [7:0] run_status;
  logic [6:0] first_db;
  logic       want_second;
  mode_t      mode;
  logic [7:0] text_left;

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // one received byte through the parser, queueing the result it gives
  task automatic assemble_byte(input logic [7:0] b);
    result_t r;
    int      len;
    logic    last;
    r = '0;
    case (mode)
      MODE_LEN: begin
        len = int'(b);
        if (len > MAX_TEXT - 1) len = MAX_TEXT - 1;
        text_left = len[7:0];
        mode = (len == 0) ? MODE_MIDI : MODE_TEXT;
      end
      MODE_TEXT: begin
        last = (text_left <= 8'd1);
        text_left = last ? 8'd0 : text_left - 8'd1;
        if (last) mode = MODE_MIDI;
        if (show_text) begin
          r.kind = KIND_TEXT;
          r.text_byte = b;
          r.text_last = last;
          owed_results.push_back(r);
        end
      end
      default: begin
        if ((b & STATUS_BIT_MASK) != DATA_ZERO) begin
          run_status = b;
          have_status = 1'b1;
          want_second = 1'b0;
        end else if (have_status) begin
          if (!want_second) begin
            if ((run_status & STATUS_HI_MASK) == STATUS_PROG ||
                (run_status & STATUS_HI_MASK) == STATUS_CHAN_AT) begin
              r.kind = KIND_MIDI;
              r.status_byte = run_status;
              r.data_first = b[6:0];
              owed_results.push_back(r);
            end else begin
              first_db = b[6:0];
              want_second = 1'b1;
            end
          end else begin
            want_second = 1'b0;
            // meta status with two zero data bytes opens a comment
            if (run_status == STATUS_META && first_db == DATA_ZERO[6:0] && b == DATA_ZERO) begin
              mode = MODE_LEN;
              have_status = 1'b0;
              run_status = '0;
              first_db = '0;
            end else begin
              r.kind = KIND_MIDI;
              r.status_byte = run_status;
              r.data_first = first_db;
              r.data_second = b[6:0];
              owed_results.push_back(r);
            end
          end
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      owed_results.delete();
      show_text = 1'b0;
      have_status = 1'b0;
      run_status = '0;
      first_db = '0;
      want_second = 1'b0;
      mode = MODE_MIDI;
      text_left = '0;
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) show_text = cfg_show_comments;
      if (in_valid && !in_stall) assemble_byte(in_rx_byte);
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          $display("%0t: result with none expected, expected none actual kind %0h status %0h",
                   $time, out_kind, out_status_byte);
          fail_count++;
        end else begin
          want = owed_results.pop_front();
          check_field("kind", 8'(want.kind), 8'(out_kind));
          check_field("status_byte", want.status_byte, out_status_byte);
          check_field("data_first", 8'(want.data_first), 8'(out_data_first));
          check_field("data_second", 8'(want.data_second), 8'(out_data_second));
          check_field("text_byte", want.text_byte, out_text_byte);
          check_field("text_last", 8'(want.text_last), 8'(out_text_last));
        end
      end
    end
    pending = owed_results.size();
  end

endmodule

// ===== tb/sv/midi_message_assembler_unit_tb.sv =====
// ----------------------------------------------------------------------------
// midi_message_assembler_unit_tb
// Feeds the MIDI message assembler with directed byte streams and then with
// random messages, comments and noise, under random gaps and stalls on both
// sides and with show_comments switched between phases.
// ----------------------------------------------------------------------------
module midi_message_assembler_unit_tb;
  import mma_pkg::*;

  localparam int MAX_TEXT     = 256;
  localparam int ITEM_GOAL    = 1400;
  localparam int LATENCY_WAIT = 6;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int LONG_HOLD    = 300;

  // data before status, running status, status mid-message, one-data
  // statuses, a comment with top-bit text, data after a comment, empty comment
  localparam logic [7:0] WARMUP [27] = '{
    8'h05, 8'h90, 8'h3C, 8'h7F, 8'h00, 8'h40, 8'h80, 8'h11, 8'hB0, 8'h01,
    8'h02, STATUS_PROG | 8'h05, 8'h7F, STATUS_CHAN_AT, DATA_ZERO,
    STATUS_META, DATA_ZERO, DATA_ZERO, 8'h03, 8'h80, 8'hFF, 8'h41, 8'h10,
    STATUS_META, DATA_ZERO, DATA_ZERO, DATA_ZERO
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_show_comments = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] in_rx_byte = '0;
  logic       out_stall = 1'b1;
  logic       cfg_ready;
  logic       in_stall;
  logic       out_valid;
  logic       out_kind;
  logic [7:0] out_status_byte;
  logic [6:0] out_data_first;
  logic [6:0] out_data_second;
  logic [7:0] out_text_byte;
  logic       out_text_last;

  int fail_count;
  int pending;
  int bytes_sent = 0;
  int msgs_taken = 0;
  int tx_streak = 0;
  bit tx_fast = 1'b0;
  bit long_done = 1'b0;

  midi_message_assembler_unit #(.MAX_TEXT(MAX_TEXT)) dut (
    .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_show_comments,
    .in_valid, .in_stall, .in_rx_byte,
    .out_valid, .out_stall, .out_kind, .out_status_byte, .out_data_first,
    .out_data_second, .out_text_byte, .out_text_last
  );

  midi_message_assembler_checker #(.MAX_TEXT(MAX_TEXT)) u_checker (
    .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_show_comments,
    .in_valid, .in_stall, .in_rx_byte,
    .out_valid, .out_stall, .out_kind, .out_status_byte, .out_data_first,
    .out_data_second, .out_text_byte, .out_text_last,
    .fail_count, .pending
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (tx_streak == 0) begin
      tx_streak = $urandom_range(10, 40);
      tx_fast = ($urandom_range(0, 2) == 0);
    end
    tx_streak--;
    gap = tx_fast ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic write_show(input logic val);
    cfg_valid <= 1'b1;
    cfg_show_comments <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait for every owed result, then give bytes that make none time to clear
  task automatic drain();
    int guard;
    in_valid <= 1'b0;
    guard = 0;
    while (pending != 0 && guard < DRAIN_LIMIT) begin
      @(negedge clk);
      guard++;
    end
    repeat (LATENCY_WAIT) @(negedge clk);
  endtask

  task automatic send_random_sequence();
    int         pick;
    int         n;
    int         len;
    logic [7:0] st;
    bit         one_data;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      // well-formed messages, often several under one running status
      st = 8'h80 | 8'($urandom_range(0, 127));
      one_data = ((st & STATUS_HI_MASK) == STATUS_PROG) ||
                 ((st & STATUS_HI_MASK) == STATUS_CHAN_AT);
      if ($urandom_range(0, 5) != 0) send_byte(st);
      n = $urandom_range(1, 4);
      repeat (n) begin
        send_byte(8'($urandom_range(0, 127)));
        if (!one_data) send_byte(8'($urandom_range(0, 127)));
      end
    end else if (pick < 72) begin
      send_byte(STATUS_META);
      send_byte(DATA_ZERO);
      send_byte(DATA_ZERO);
      if (!long_done || $urandom_range(0, 40) == 0) len = 255;
      else len = $urandom_range(0, 9);
      long_done = 1'b1;
      send_byte(8'(len));
      repeat (len) send_byte(8'($urandom_range(0, 255)));
    end else if (pick < 85) begin
      // message cut short by whatever comes next
      send_byte(8'h80 | 8'($urandom_range(0, 127)));
      if ($urandom_range(0, 1) == 1) send_byte(8'($urandom_range(0, 127)));
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // receiver: random stalls per item, fast stretches, two long hold-offs
  initial begin
    int hold;
    int streak;
    bit fast;
    streak = 0;
    fast = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (streak == 0) begin
        streak = $urandom_range(10, 40);
        fast = ($urandom_range(0, 2) == 0);
      end
      streak--;
      hold = fast ? 0 : $urandom_range(0, 18);
      if (msgs_taken == 60 || msgs_taken == 400) hold = LONG_HOLD;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      msgs_taken++;
      @(negedge clk);
    end
  end

  initial begin
    int phase;
    int goal;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    write_show(1'b1);
    foreach (WARMUP[i]) send_byte(WARMUP[i]);
    phase = 0;
    while (bytes_sent < ITEM_GOAL) begin
      drain();
      if (phase == 0) write_show(1'b0);
      else if (phase == 1) write_show(1'b1);
      else write_show(1'($urandom_range(0, 1)));
      phase++;
      goal = bytes_sent + $urandom_range(150, 250);
      while (bytes_sent < goal) send_random_sequence();
    end
    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
